@@ rtl/core/hrhp_pkg.sv @@
// hrhp_pkg: shared types, codes and match strings for the request header parser
// no dependencies; used by the interfaces, the core and the checker
package hrhp_pkg;

   // parse phases
   localparam logic [2:0] PH_METHOD = 3'd0;
   localparam logic [2:0] PH_URI    = 3'd1;
   localparam logic [2:0] PH_VER    = 3'd2;
   localparam logic [2:0] PH_VER_LF = 3'd3;
   localparam logic [2:0] PH_NAME   = 3'd4;
   localparam logic [2:0] PH_SKIP   = 3'd5;
   localparam logic [2:0] PH_VALUE  = 3'd6;

   // result kinds
   localparam logic [1:0] KIND_URI      = 2'd0;
   localparam logic [1:0] KIND_COMPLETE = 2'd1;
   localparam logic [1:0] KIND_ERROR    = 2'd2;

   // method codes
   localparam logic [1:0] METHOD_OTHER = 2'd0;
   localparam logic [1:0] METHOD_GET   = 2'd1;
   localparam logic [1:0] METHOD_POST  = 2'd2;

   // register indexes
   localparam logic CSR_URI_LIMIT   = 1'b0;
   localparam logic CSR_TOKEN_LIMIT = 1'b1;

   // number scan steps
   localparam logic [1:0] SCAN_BLANKS = 2'd0;
   localparam logic [1:0] SCAN_DIGITS = 2'd1;
   localparam logic [1:0] SCAN_DONE   = 2'd2;

   // characters
   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_LF    = 8'h0a;
   localparam logic [7:0] CH_COLON = 8'h3a;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2b;
   localparam logic [7:0] CH_MINUS = 8'h2d;

   // match strings, right aligned in 14 characters
   localparam logic [111:0] STR_GET   = 112'("get");
   localparam logic [111:0] STR_POST  = 112'("post");
   localparam logic [111:0] STR_CONN  = 112'("connection");
   localparam logic [111:0] STR_CLEN  = 112'("content-length");
   localparam logic [111:0] STR_KEEP  = 112'("keep-alive");
   localparam logic [111:0] STR_CLOSE = 112'("close");

   localparam logic [31:0] MAG_CAP = 32'h8000_0000;

   typedef logic [1:0] kind_type;

   // true when c equals the string character at position pos
   function automatic logic str_hit(input logic [111:0] str, input logic [3:0] len,
                                    input logic [9:0] pos, input logic [7:0] c);
      logic [6:0] idx;
      idx = 7'd0;
      if ({6'd0, pos} >= {12'd0, len}) begin
         return 1'b0;
      end
      idx = 7'(({3'd0, len} - 7'd1 - pos[6:0]) << 3);
      return str[idx +: 8] == c;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5a) ? c + 8'd32 : c;
   endfunction

endpackage

@@ rtl/core/hrhp_if.sv @@
// hrhp_req_if / hrhp_rsp_if: valid/ready channels of the request header parser
// depends on hrhp_pkg
interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface hrhp_rsp_if;
   logic                valid;
   logic                ready;
   hrhp_pkg::kind_type  result_kind;
   logic [7:0]          uri_char;
   logic [1:0]          method_code;
   logic                keep_alive;
   logic signed [31:0]  content_length;
   logic [11:0]         uri_length;
   modport source (output valid, output result_kind, output uri_char, output method_code,
                   output keep_alive, output content_length, output uri_length,
                   input ready);
   modport sink (input valid, input result_kind, input uri_char, input method_code,
                 input keep_alive, input content_length, input uri_length,
                 output ready);
endinterface

@@ rtl/core/http_request_header_parser_core.sv @@
// http_request_header_parser_core: byte-wide HTTP/1.1 request header parser
// depends on hrhp_pkg and hrhp_if (hrhp_req_if, hrhp_rsp_if)
//
//   channel  | direction | beat contents
//   req_ch   | in        | in_byte
//   rsp_ch   | out       | result_kind, uri_char, method_code, keep_alive,
//            |           | content_length, uri_length
//   csr_*    | in        | write enable, register index, 12-bit data
//
// One byte is taken per cycle; a byte that yields a result beat has it in the output register the next cycle.
// The only limit on rate is the single result register: a byte is taken whenever
// that register is empty or is being read in the same cycle.
// Synchronous reset returns to the method phase with limits 255 and 199.
module http_request_header_parser_core (
   input  logic         clock,
   input  logic         reset,
   hrhp_req_if.sink     req_ch,
   hrhp_rsp_if.source   rsp_ch,
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [11:0]  csr_wdata
);

   // registers
   logic [11:0] uri_limit_ff, uri_limit_in;
   logic [9:0]  token_limit_ff, token_limit_in;
   logic [2:0]  phase_ff, phase_in;
   logic [9:0]  count_ff, count_in;
   logic [3:0]  name_ff, name_in;
   logic [1:0]  value_ff, value_in;
   logic [31:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        keep_ff, keep_in;
   logic [1:0]  method_ff, method_in;
   logic        cr_ff, cr_in;
   logic        empty_ff, empty_in;
   logic [11:0] uri_ff, uri_in;
   logic [31:0] clen_ff, clen_in;
   logic [1:0]  step_ff, step_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  char_ff, char_in;
   logic [1:0]  rmethod_ff, rmethod_in;
   logic        rkeep_ff, rkeep_in;
   logic [31:0] rclen_ff, rclen_in;
   logic [11:0] ruri_ff, ruri_in;

   logic        fire;
   logic [7:0]  c;
   logic [7:0]  lc;
   logic        emit_s;
   logic        fail_s;
   logic        done_s;
   logic        begin_s;
   logic        skip_s;
   logic        digit;
   logic [35:0] mag;
   logic [3:0]  nm;
   logic [9:0]  cc;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;
   assign c            = req_ch.in_byte;
   assign lc           = hrhp_pkg::to_lower(c);
   assign digit        = c >= 8'h30 && c <= 8'h39;

   // configuration writes
   always_comb begin
      uri_limit_in   = uri_limit_ff;
      token_limit_in = token_limit_ff;
      if (csr_we) begin
         unique case (csr_index)
            hrhp_pkg::CSR_URI_LIMIT:   uri_limit_in = csr_wdata;
            hrhp_pkg::CSR_TOKEN_LIMIT: token_limit_in = csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // per-byte parse step
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      name_in   = name_ff;
      value_in  = value_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      keep_in   = keep_ff;
      method_in = method_ff;
      cr_in     = cr_ff;
      empty_in  = empty_ff;
      uri_in    = uri_ff;
      clen_in   = clen_ff;
      step_in   = step_ff;
      emit_s    = 1'b0;
      fail_s    = 1'b0;
      done_s    = 1'b0;
      begin_s   = 1'b0;
      skip_s    = 1'b0;
      kind_in   = kind_ff;
      char_in   = char_ff;
      mag       = {4'd0, acc_ff};
      nm        = name_ff;
      cc        = count_ff;
      if (fire) begin
         unique case (phase_ff)
            hrhp_pkg::PH_METHOD: begin
               if (c == hrhp_pkg::CH_SPACE) begin
                  if (name_ff[0] && count_ff == 10'd3) method_in = hrhp_pkg::METHOD_GET;
                  else if (name_ff[1] && count_ff == 10'd4) method_in = hrhp_pkg::METHOD_POST;
                  else method_in = hrhp_pkg::METHOD_OTHER;
                  phase_in = hrhp_pkg::PH_URI;
                  count_in = '0;
               end else if (count_ff >= token_limit_ff) begin
                  fail_s = 1'b1;
               end else begin
                  name_in[0] = name_ff[0] &&
                               hrhp_pkg::str_hit(hrhp_pkg::STR_GET, 4'd3, count_ff, lc);
                  name_in[1] = name_ff[1] &&
                               hrhp_pkg::str_hit(hrhp_pkg::STR_POST, 4'd4, count_ff, lc);
                  count_in = count_ff + 10'd1;
               end
            end
            hrhp_pkg::PH_URI: begin
               if (c == hrhp_pkg::CH_SPACE) begin
                  phase_in = hrhp_pkg::PH_VER;
                  count_in = '0;
               end else if (uri_ff >= uri_limit_ff) begin
                  fail_s = 1'b1;
               end else begin
                  uri_in  = uri_ff + 12'd1;
                  emit_s  = 1'b1;
                  kind_in = hrhp_pkg::KIND_URI;
                  char_in = c;
               end
            end
            hrhp_pkg::PH_VER, hrhp_pkg::PH_VER_LF: begin
               if (phase_ff == hrhp_pkg::PH_VER && c == hrhp_pkg::CH_CR) begin
                  phase_in = hrhp_pkg::PH_VER_LF;
                  count_in = '0;
               end else if (phase_ff == hrhp_pkg::PH_VER_LF && c == hrhp_pkg::CH_LF) begin
                  begin_s = 1'b1;
               end else if (count_ff >= token_limit_ff) begin
                  fail_s = 1'b1;
               end else begin
                  count_in = count_ff + 10'd1;
               end
            end
            default: begin
               if (cr_ff) begin
                  cr_in = 1'b0;
                  // line ending
                  if (c == hrhp_pkg::CH_LF) begin
                     if (phase_ff == hrhp_pkg::PH_NAME) begin
                        if (name_ff[0] && count_ff == 10'd10) nm[2] = 1'b1;
                        if (name_ff[1] && count_ff == 10'd14) nm[3] = 1'b1;
                        cc = '0;
                     end
                     if (nm[2]) begin
                        if (value_ff[0] && cc == 10'd10) keep_in = 1'b1;
                        else if (value_ff[1] && cc == 10'd5) keep_in = 1'b0;
                     end else if (nm[3]) begin
                        if (neg_ff) clen_in = 32'd0 - acc_ff;
                        else clen_in = (acc_ff >= hrhp_pkg::MAG_CAP) ? 32'h7fff_ffff : acc_ff;
                     end
                     if (empty_ff) done_s = 1'b1;
                     else begin_s = 1'b1;
                  end
               end else if (c == hrhp_pkg::CH_CR) begin
                  cr_in = 1'b1;
                  if (phase_ff == hrhp_pkg::PH_SKIP) phase_in = hrhp_pkg::PH_VALUE;
               end else if (phase_ff == hrhp_pkg::PH_NAME) begin
                  if (c == hrhp_pkg::CH_COLON) begin
                     if (name_ff[0] && count_ff == 10'd10) name_in[2] = 1'b1;
                     if (name_ff[1] && count_ff == 10'd14) name_in[3] = 1'b1;
                     count_in = '0;
                     phase_in = hrhp_pkg::PH_SKIP;
                  end else if (count_ff >= token_limit_ff) begin
                     fail_s = 1'b1;
                  end else begin
                     empty_in   = 1'b0;
                     name_in[0] = name_ff[0] &&
                                  hrhp_pkg::str_hit(hrhp_pkg::STR_CONN, 4'd10, count_ff, lc);
                     name_in[1] = name_ff[1] &&
                                  hrhp_pkg::str_hit(hrhp_pkg::STR_CLEN, 4'd14, count_ff, lc);
                     count_in = count_ff + 10'd1;
                  end
               end else if (!(phase_ff == hrhp_pkg::PH_SKIP && c == hrhp_pkg::CH_SPACE)) begin
                  phase_in = hrhp_pkg::PH_VALUE;
                  if (count_ff >= token_limit_ff) begin
                     fail_s = 1'b1;
                  end else begin
                     value_in[0] = value_ff[0] &&
                                   hrhp_pkg::str_hit(hrhp_pkg::STR_KEEP, 4'd10, count_ff, c);
                     value_in[1] = value_ff[1] &&
                                   hrhp_pkg::str_hit(hrhp_pkg::STR_CLOSE, 4'd5, count_ff, c);
                     count_in = count_ff + 10'd1;
                     // number scan: blanks, sign, digits
                     if (step_ff == hrhp_pkg::SCAN_BLANKS) begin
                        if (c == hrhp_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
                           skip_s = 1'b1;
                        end else if (c == hrhp_pkg::CH_PLUS || c == hrhp_pkg::CH_MINUS) begin
                           neg_in  = c == hrhp_pkg::CH_MINUS;
                           step_in = hrhp_pkg::SCAN_DIGITS;
                           skip_s  = 1'b1;
                        end else begin
                           step_in = digit ? hrhp_pkg::SCAN_DIGITS : hrhp_pkg::SCAN_DONE;
                        end
                     end
                     if (!skip_s && step_in == hrhp_pkg::SCAN_DIGITS) begin
                        if (digit) begin
                           mag = {1'b0, acc_ff, 3'd0} + {3'd0, acc_ff, 1'b0} +
                                 {32'd0, c[3:0]};
                           acc_in = (mag > {4'd0, hrhp_pkg::MAG_CAP}) ?
                                    hrhp_pkg::MAG_CAP : mag[31:0];
                        end else begin
                           step_in = hrhp_pkg::SCAN_DONE;
                        end
                     end
                  end
               end
            end
         endcase
         // error and completion beats
         if (fail_s) begin
            emit_s  = 1'b1;
            kind_in = hrhp_pkg::KIND_ERROR;
            char_in = '0;
         end else if (done_s) begin
            emit_s  = 1'b1;
            kind_in = hrhp_pkg::KIND_COMPLETE;
            char_in = '0;
         end
      end
      // snapshot for the result beat
      rmethod_in = emit_s ? method_in : rmethod_ff;
      rkeep_in   = emit_s ? keep_in : rkeep_ff;
      rclen_in   = emit_s ? clen_in : rclen_ff;
      ruri_in    = emit_s ? uri_in : ruri_ff;
      // start of a header line, or of a new request
      if (begin_s || fail_s || done_s) begin
         phase_in = hrhp_pkg::PH_NAME;
         count_in = '0;
         name_in  = 4'b0011;
         value_in = 2'b11;
         acc_in   = '0;
         neg_in   = 1'b0;
         step_in  = hrhp_pkg::SCAN_BLANKS;
         cr_in    = 1'b0;
         empty_in = 1'b1;
      end
      if (fail_s || done_s) begin
         phase_in  = hrhp_pkg::PH_METHOD;
         keep_in   = 1'b0;
         method_in = hrhp_pkg::METHOD_OTHER;
         uri_in    = '0;
         clen_in   = '0;
      end
   end

   // result register valid
   always_comb begin
      if (emit_s) rsp_valid_in = 1'b1;
      else if (rsp_ch.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         uri_limit_ff   <= 12'd255;
         token_limit_ff <= 10'd199;
         phase_ff       <= hrhp_pkg::PH_METHOD;
         count_ff       <= '0;
         name_ff        <= 4'b0011;
         value_ff       <= 2'b11;
         acc_ff         <= '0;
         neg_ff         <= 1'b0;
         keep_ff        <= 1'b0;
         method_ff      <= hrhp_pkg::METHOD_OTHER;
         cr_ff          <= 1'b0;
         empty_ff       <= 1'b1;
         uri_ff         <= '0;
         clen_ff        <= '0;
         step_ff        <= hrhp_pkg::SCAN_BLANKS;
         rsp_valid_ff   <= 1'b0;
      end else begin
         uri_limit_ff   <= uri_limit_in;
         token_limit_ff <= token_limit_in;
         phase_ff       <= phase_in;
         count_ff       <= count_in;
         name_ff        <= name_in;
         value_ff       <= value_in;
         acc_ff         <= acc_in;
         neg_ff         <= neg_in;
         keep_ff        <= keep_in;
         method_ff      <= method_in;
         cr_ff          <= cr_in;
         empty_ff       <= empty_in;
         uri_ff         <= uri_in;
         clen_ff        <= clen_in;
         step_ff        <= step_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      char_ff    <= char_in;
      rmethod_ff <= rmethod_in;
      rkeep_ff   <= rkeep_in;
      rclen_ff   <= rclen_in;
      ruri_ff    <= ruri_in;
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.result_kind    = kind_ff;
   assign rsp_ch.uri_char       = char_ff;
   assign rsp_ch.method_code    = rmethod_ff;
   assign rsp_ch.keep_alive     = rkeep_ff;
   assign rsp_ch.content_length = rclen_ff;
   assign rsp_ch.uri_length     = ruri_ff;

endmodule

@@ rtl/core/hrhp_checker.sv @@
// hrhp_checker: port-level assertions for the request header parser core
// depends on hrhp_pkg; bound to http_request_header_parser_core below
module hrhp_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  result_kind,
   input logic [7:0]  uri_char
);

   // a pending result beat holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(result_kind) && $stable(uri_char))
      else $error("result beat dropped or changed under stall");

   // an empty result register always takes input
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled with empty result register");

   // no result right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat after reset");

   // only uri beats carry a character, and kind three never appears
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && result_kind != hrhp_pkg::KIND_URI |->
         uri_char == 8'd0 &&
         (result_kind == hrhp_pkg::KIND_COMPLETE || result_kind == hrhp_pkg::KIND_ERROR))
      else $error("bad non-uri result beat");

endmodule

bind http_request_header_parser_core hrhp_checker u_hrhp_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .result_kind (rsp_ch.result_kind),
   .uri_char    (rsp_ch.uri_char)
);

@@ sim/hrhp_checker.sv @@
// hrhp_result_check: predicts and checks every result beat of the request header parser
// depends on hrhp_pkg and the channel interfaces hrhp_req_if / hrhp_rsp_if
module hrhp_result_check (
   input  logic        clock,
   input  logic        reset,
   hrhp_req_if         req_mon,
   hrhp_rsp_if         rsp_mon,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [11:0] csr_wdata,
   output int          fail_count,
   output int          pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [1:0]         kind;
      logic [7:0]         ch;
      logic [1:0]         meth;
      logic               alive;
      logic signed [31:0] clen;
      logic [11:0]        ulen;
   } header_result_type;

   header_result_type due_q[$];

   // parser shadow state
   logic [11:0] uri_lim;
   logic [9:0]  tok_lim;
   logic [2:0]  phase;
   int          cnt;
   logic        cand_a, cand_b, is_conn, is_clen;
   logic        val_keep, val_close;
   logic [31:0] acc;
   logic        neg;
   logic [1:0]  scan;
   logic        ka_flag;
   logic [1:0]  meth;
   logic        crp;
   logic        lempty;
   logic [11:0] uric;
   logic [31:0] clen;

   function automatic logic hit(input string s, input int pos, input logic [7:0] c);
      if (pos >= s.len()) begin
         return 1'b0;
      end
      return c == s[pos];
   endfunction

   function automatic void post(input logic [1:0] kind, input logic [7:0] ch);
      header_result_type r;
      r.kind  = kind;
      r.ch    = ch;
      r.meth  = meth;
      r.alive = ka_flag;
      r.clen  = clen;
      r.ulen  = uric;
      due_q.push_back(r);
   endfunction

   function automatic void open_line();
      phase    = hrhp_pkg::PH_NAME;
      cnt      = 0;
      cand_a   = 1'b1;
      cand_b   = 1'b1;
      is_conn  = 1'b0;
      is_clen  = 1'b0;
      val_keep = 1'b1;
      val_close = 1'b1;
      acc      = 32'd0;
      neg      = 1'b0;
      scan     = hrhp_pkg::SCAN_BLANKS;
      crp      = 1'b0;
      lempty   = 1'b1;
   endfunction

   function automatic void restart();
      open_line();
      phase   = hrhp_pkg::PH_METHOD;
      ka_flag = 1'b0;
      meth    = hrhp_pkg::METHOD_OTHER;
      uric    = 12'd0;
      clen    = 32'd0;
   endfunction

   function automatic void overflow();
      post(hrhp_pkg::KIND_ERROR, 8'd0);
      restart();
   endfunction

   function automatic void settle_name();
      if (cand_a && cnt == 10) begin
         is_conn = 1'b1;
      end
      if (cand_b && cnt == 14) begin
         is_clen = 1'b1;
      end
      cnt = 0;
   endfunction

   // atoi-style scan with saturating magnitude
   function automatic void scan_value(input logic [7:0] c);
      logic       digit;
      logic [63:0] m;
      digit = (c >= "0" && c <= "9");
      if (scan == hrhp_pkg::SCAN_BLANKS) begin
         if (c == hrhp_pkg::CH_SPACE || (c >= 8'd9 && c <= 8'd13)) begin
            return;
         end
         if (c == hrhp_pkg::CH_PLUS || c == hrhp_pkg::CH_MINUS) begin
            neg  = (c == hrhp_pkg::CH_MINUS);
            scan = hrhp_pkg::SCAN_DIGITS;
            return;
         end
         scan = digit ? hrhp_pkg::SCAN_DIGITS : hrhp_pkg::SCAN_DONE;
      end
      if (scan == hrhp_pkg::SCAN_DIGITS) begin
         if (digit) begin
            m = 64'(acc) * 64'd10 + 64'(c - "0");
            acc = (m > 64'(hrhp_pkg::MAG_CAP)) ? hrhp_pkg::MAG_CAP : m[31:0];
         end else begin
            scan = hrhp_pkg::SCAN_DONE;
         end
      end
   endfunction

   function automatic void close_line();
      if (phase == hrhp_pkg::PH_NAME) begin
         settle_name();
      end
      if (is_conn) begin
         if (val_keep && cnt == 10) begin
            ka_flag = 1'b1;
         end else if (val_close && cnt == 5) begin
            ka_flag = 1'b0;
         end
      end else if (is_clen) begin
         if (neg) begin
            clen = 32'd0 - acc;
         end else begin
            clen = (acc >= hrhp_pkg::MAG_CAP) ? 32'h7fff_ffff : acc;
         end
      end
      if (lempty) begin
         post(hrhp_pkg::KIND_COMPLETE, 8'd0);
         restart();
      end else begin
         open_line();
      end
   endfunction

   function automatic void parse_byte(input logic [7:0] c);
      logic [7:0] lc;
      lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
      case (phase)
         hrhp_pkg::PH_METHOD: begin
            if (c == hrhp_pkg::CH_SPACE) begin
               if (cand_a && cnt == 3) begin
                  meth = hrhp_pkg::METHOD_GET;
               end else if (cand_b && cnt == 4) begin
                  meth = hrhp_pkg::METHOD_POST;
               end else begin
                  meth = hrhp_pkg::METHOD_OTHER;
               end
               phase = hrhp_pkg::PH_URI;
               cnt   = 0;
               return;
            end
            if (cnt >= tok_lim) begin
               overflow();
               return;
            end
            cand_a = cand_a && hit("get", cnt, lc);
            cand_b = cand_b && hit("post", cnt, lc);
            cnt++;
            return;
         end
         hrhp_pkg::PH_URI: begin
            if (c == hrhp_pkg::CH_SPACE) begin
               phase = hrhp_pkg::PH_VER;
               cnt   = 0;
               return;
            end
            if (uric >= uri_lim) begin
               overflow();
               return;
            end
            uric++;
            post(hrhp_pkg::KIND_URI, c);
            return;
         end
         hrhp_pkg::PH_VER, hrhp_pkg::PH_VER_LF: begin
            if (c == (phase == hrhp_pkg::PH_VER ? hrhp_pkg::CH_CR : hrhp_pkg::CH_LF)) begin
               if (phase == hrhp_pkg::PH_VER) begin
                  phase = hrhp_pkg::PH_VER_LF;
                  cnt   = 0;
               end else begin
                  open_line();
               end
               return;
            end
            if (cnt >= tok_lim) begin
               overflow();
               return;
            end
            cnt++;
            return;
         end
         default: ;
      endcase

      // header lines
      if (crp) begin
         crp = 1'b0;
         if (c == hrhp_pkg::CH_LF) begin
            close_line();
         end
         return;
      end
      if (c == hrhp_pkg::CH_CR) begin
         crp = 1'b1;
         if (phase == hrhp_pkg::PH_SKIP) begin
            phase = hrhp_pkg::PH_VALUE;
         end
         return;
      end
      if (phase == hrhp_pkg::PH_NAME) begin
         if (c == hrhp_pkg::CH_COLON) begin
            settle_name();
            phase = hrhp_pkg::PH_SKIP;
            return;
         end
         if (cnt >= tok_lim) begin
            overflow();
            return;
         end
         lempty = 1'b0;
         cand_a = cand_a && hit("connection", cnt, lc);
         cand_b = cand_b && hit("content-length", cnt, lc);
         cnt++;
         return;
      end
      if (phase == hrhp_pkg::PH_SKIP) begin
         if (c == hrhp_pkg::CH_SPACE) begin
            return;
         end
         phase = hrhp_pkg::PH_VALUE;
      end
      if (cnt >= tok_lim) begin
         overflow();
         return;
      end
      val_keep  = val_keep && hit("keep-alive", cnt, c);
      val_close = val_close && hit("close", cnt, c);
      scan_value(c);
      cnt++;
   endfunction

   // compare result beats, then advance the shadow parser on input beats
   always @(posedge clock) begin
      header_result_type e;
      if (reset) begin
         uri_lim = 12'd255;
         tok_lim = 10'd199;
         restart();
         due_q.delete();
         fail_count <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_q.size() == 0) begin
               $display("%0t: unexpected result beat kind %0d char %0h", $realtime,
                        rsp_mon.result_kind, rsp_mon.uri_char);
               fail_count <= fail_count + 1;
            end else begin
               e = due_q.pop_front();
               if (rsp_mon.result_kind !== e.kind || rsp_mon.uri_char !== e.ch ||
                   rsp_mon.method_code !== e.meth || rsp_mon.keep_alive !== e.alive ||
                   rsp_mon.content_length !== e.clen || rsp_mon.uri_length !== e.ulen) begin
                  $display({"%0t: mismatch expected kind %0d char %0h meth %0d ka %0b",
                            " clen %0d ulen %0d"},
                           $realtime, e.kind, e.ch, e.meth, e.alive, e.clen, e.ulen);
                  $display({"%0t:          actual kind %0d char %0h meth %0d ka %0b",
                            " clen %0d ulen %0d"},
                           $realtime, rsp_mon.result_kind, rsp_mon.uri_char,
                           rsp_mon.method_code, rsp_mon.keep_alive,
                           rsp_mon.content_length, rsp_mon.uri_length);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (csr_we) begin
            if (csr_index == hrhp_pkg::CSR_URI_LIMIT) begin
               uri_lim = csr_wdata;
            end else begin
               tok_lim = csr_wdata[9:0];
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            parse_byte(req_mon.in_byte);
         end
      end
      pending <= due_q.size();
   end
endmodule

@@ sim/http_request_header_parser_core_test.sv @@
// http_request_header_parser_core_test: request stream stimulus and verdict
// depends on hrhp_pkg, hrhp_if, the core and hrhp_result_check
module http_request_header_parser_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = hrhp_pkg::CSR_URI_LIMIT;
   logic [11:0] csr_wdata = 12'd0;
   int          fail_count;
   int          pending;
   int          sent = 0;
   int          cycles = 0;
   bit          calm = 1'b0;
   bit          do_hold = 1'b0;
   logic [7:0]  stream_q[$];

   hrhp_req_if req_ch ();
   hrhp_rsp_if rsp_ch ();

   http_request_header_parser_core dut (
      .clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   hrhp_result_check u_checker (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.in_byte = 8'd0;
      rsp_ch.ready   = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("FAIL");
         $finish;
      end
   end

   // receiver with stall bursts and long hold-offs
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_ch.ready <= 1'b0;
         end else if (do_hold) begin
            do_hold = 1'b0;
            stall = 300;
            rsp_ch.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall = $urandom_range(0, 6);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.in_byte <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent++;
   endtask

   task automatic flush_stream();
      while (stream_q.size() > 0) send_byte(stream_q.pop_front());
      req_ch.valid <= 1'b0;
   endtask

   function automatic void add_text(input string s);
      foreach (s[i]) stream_q.push_back(s[i]);
   endfunction

   function automatic void add_crlf();
      stream_q.push_back(hrhp_pkg::CH_CR);
      stream_q.push_back(hrhp_pkg::CH_LF);
   endfunction

   function automatic void add_random(input int n, input bit any);
      logic [7:0] b;
      repeat (n) begin
         b = $urandom_range(0, 255);
         if (!any && (b == hrhp_pkg::CH_SPACE || b == hrhp_pkg::CH_CR ||
                      b == hrhp_pkg::CH_LF || b == hrhp_pkg::CH_COLON)) begin
            b = b ^ 8'h40;
         end
         stream_q.push_back(b);
      end
   endfunction

   function automatic string number_text();
      string s;
      case ($urandom_range(0, 11))
         0: s = "123";
         1: s = "-45";
         2: s = "+7";
         3: s = "  \t99";
         4: s = "99999999999";
         5: s = "-99999999999";
         6: s = "2147483648";
         7: s = "-2147483648";
         8: s = "12ab";
         9: s = "";
         10: s = "- 5";
         default: s = $sformatf("%0d", $urandom());
      endcase
      return s;
   endfunction

   // one request, mostly well formed with random content
   function automatic void add_request();
      int kind;
      string methods[8] = '{"GET", "get", "POST", "PoSt", "PUT", "GE", "GETX", "POSTS"};
      add_text(methods[$urandom_range(0, 7)]);
      stream_q.push_back(hrhp_pkg::CH_SPACE);
      add_random(($urandom_range(0, 15) == 0) ? $urandom_range(200, 300)
                                               : $urandom_range(1, 12), 1'b0);
      stream_q.push_back(hrhp_pkg::CH_SPACE);
      add_text("HTTP/1.1");
      add_crlf();
      repeat ($urandom_range(0, 5)) begin
         kind = $urandom_range(0, 11);
         case (kind)
            0: add_text("Connection: keep-alive");
            1: add_text("connection: close");
            2: add_text("CONNECTION:   keep-alive");
            3: add_text("Connection: Keep-Alive");
            4, 5: add_text({"Content-Length: ", number_text()});
            6: begin
               add_random($urandom_range(1, 10), 1'b0);
               add_text(": ");
               add_random($urandom_range(0, 20), 1'b0);
            end
            7: begin
               // stray carriage return inside a value
               add_text("X-Tag: ab");
               stream_q.push_back(hrhp_pkg::CH_CR);
               add_text("cd");
            end
            8: begin
               // carriage return right after the colon, not followed by line feed
               add_text("Content-Length:");
               stream_q.push_back(hrhp_pkg::CH_CR);
               add_text("Z  42");
            end
            9: add_text("Content-Length");
            10: add_text("Content-Length:");
            default: add_text(":oops");
         endcase
         add_crlf();
      end
      add_crlf();
   endfunction

   task automatic write_csr(input logic idx, input logic [11:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // wait until every predicted result beat has been taken
   task automatic go_idle();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [11:0] uri_set[5] = '{12'd255, 12'd1, 12'd4095, 12'd6, 12'd300};
      logic [9:0]  tok_set[5] = '{10'd199, 10'd1, 10'd1023, 10'd8, 10'd200};
      int goal;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: byte extremes in the uri, a bare header
      add_text("get /");
      stream_q.push_back(8'h00);
      stream_q.push_back(8'hff);
      add_text(" HTTP/1.1");
      add_crlf();
      add_crlf();
      flush_stream();

      for (int p = 0; p < 5; p++) begin
         go_idle();
         write_csr(hrhp_pkg::CSR_URI_LIMIT, uri_set[p]);
         write_csr(hrhp_pkg::CSR_TOKEN_LIMIT, {2'b00, tok_set[p]});
         if (p == 4) begin
            calm = 1'b1;
         end
         goal = sent + 180;
         while (sent < goal) begin
            if ($urandom_range(0, 9) == 0) begin
               add_random($urandom_range(5, 40), 1'b1);
            end else begin
               add_request();
            end
            flush_stream();
            if (p == 0 && sent > goal - 90 && sent < goal - 40) begin
               do_hold = 1'b1;
            end
            if (p == 2 && sent > goal - 90 && sent < goal - 40) begin
               go_idle();
            end
         end
      end

      go_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
